@@ rtl/queue_with_middle_insert_defines.svh @@
// Assertion macros shared by the queue RTL.
`ifndef QUEUE_WITH_MIDDLE_INSERT_DEFINES_SVH
`define QUEUE_WITH_MIDDLE_INSERT_DEFINES_SVH
`ifndef SYNTH
// Clocked assertion that is ignored while reset is high.
`define QMI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that is also checked during reset.
`define QMI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QMI_ASSERT(lbl, clk, rst, prop, msg)
`define QMI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/qmi_pkg.sv @@
// Shared codes and types of the queue with middle insertion.
`timescale 1ns / 1ps
package qmi_pkg;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_MIDDLE = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int OUT_W = 32;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage

@@ rtl/queue_with_middle_insert.sv @@
// Queue with middle insertion: a FIFO of values that can also insert at position ceil(n/2).
// Each word is handled in the accept cycle and then in state S_EXEC: in the accept cycle both
// half stores are read at their heads and any direct insert is written; in S_EXEC the element
// that moves from the head of the back half to the tail of the front half is written and the
// result is registered. A new word is taken only in S_IDLE, not while one is in S_EXEC, and only
// while the result register is free or being drained in that cycle. The stores need no clearing
// after reset: the fill counts ensure that no unwritten entry is ever read. A pop on an empty queue
// reports status empty, a push or insert at CAPACITY reports full; both leave the queue unchanged.
`timescale 1ns / 1ps
`include "queue_with_middle_insert_defines.svh"
module queue_with_middle_insert #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            op_valid,
  output logic                            op_ready,
  input  logic [1:0]                      op,
  input  logic signed [qmi_pkg::OUT_W-1:0] value,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic signed [qmi_pkg::OUT_W-1:0] popped_value,
  output logic [1:0]                      status
);

  localparam int HD    = (CAPACITY + 1) / 2;
  localparam int PTR_W = (HD > 1) ? $clog2(HD) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int EXT_W = (DATA_WIDTH > qmi_pkg::OUT_W) ? DATA_WIDTH : qmi_pkg::OUT_W;

  function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= SUM_W'(HD)) ? s - SUM_W'(HD) : s;
    return r[PTR_W-1:0];
  endfunction

  qmi_pkg::state_t state, state_next;

  logic [PTR_W-1:0] fh, fh_next, bh, bh_next;
  logic [CNT_W-1:0] ff, ff_next, bf, bf_next;

  logic [DATA_WIDTH-1:0] front_mem [HD];
  logic [DATA_WIDTH-1:0] back_mem  [HD];
  logic [DATA_WIDTH-1:0] f_rd, b_rd;

  logic                  accept;
  logic                  f_we, b_we, rd_en;
  logic [PTR_W-1:0]      f_wa, b_wa;
  logic [DATA_WIDTH-1:0] f_wd, v_store;
  logic [EXT_W-1:0]      v_ext, rd_ext;

  logic                  move_acc, pop_acc;
  logic [1:0]            status_acc;

  // Held from the accept cycle into state S_EXEC.
  logic                  move_pend, pop_pend;
  logic [PTR_W-1:0]      mv_addr;
  logic [1:0]            status_r;

  logic [SUM_W-1:0]      total;
  logic                  full, empty, rebal;
  logic [PTR_W-1:0]      fh_tail, bh_tail, fh_inc, bh_inc, bh_dec;

  assign op_ready = (state == qmi_pkg::S_IDLE) && (!res_valid || res_ready);
  assign accept   = op_valid && op_ready;

  assign v_ext   = EXT_W'($unsigned(value));
  assign v_store = v_ext[DATA_WIDTH-1:0];
  assign rd_ext  = EXT_W'(f_rd);

  assign total   = SUM_W'(ff) + SUM_W'(bf);
  assign full    = total >= SUM_W'(CAPACITY);
  assign empty   = (ff == '0);
  assign rebal   = (ff == bf);
  assign fh_tail = wrap(SUM_W'(fh) + SUM_W'(ff));
  assign bh_tail = wrap(SUM_W'(bh) + SUM_W'(bf));
  assign fh_inc  = wrap(SUM_W'(fh) + SUM_W'(1));
  assign bh_inc  = wrap(SUM_W'(bh) + SUM_W'(1));
  assign bh_dec  = (bh == '0) ? PTR_W'(HD - 1) : bh - PTR_W'(1);

  always_comb begin
    fh_next    = fh;
    bh_next    = bh;
    ff_next    = ff;
    bf_next    = bf;
    f_we       = 1'b0;
    b_we       = 1'b0;
    f_wa       = fh_tail;
    b_wa       = bh_tail;
    f_wd       = v_store;
    rd_en      = 1'b0;
    move_acc   = 1'b0;
    pop_acc    = 1'b0;
    status_acc = qmi_pkg::ST_OK;
    state_next = state;
    unique case (state)
      qmi_pkg::S_IDLE: begin
        if (accept) begin
          state_next = qmi_pkg::S_EXEC;
          rd_en      = 1'b1;
          priority if ((op == qmi_pkg::OP_PUSH || op == qmi_pkg::OP_MIDDLE) && full) begin
            status_acc = qmi_pkg::ST_FULL;
          end else if (op == qmi_pkg::OP_PUSH) begin
            if (rebal && bf == '0) begin
              // The new word is at once the head of the back half and moves forward.
              f_we    = 1'b1;
              ff_next = ff + CNT_W'(1);
            end else if (rebal) begin
              b_we     = 1'b1;
              bh_next  = bh_inc;
              ff_next  = ff + CNT_W'(1);
              move_acc = 1'b1;
            end else begin
              b_we    = 1'b1;
              bf_next = bf + CNT_W'(1);
            end
          end else if (op == qmi_pkg::OP_MIDDLE) begin
            if (rebal) begin
              f_we    = 1'b1;
              ff_next = ff + CNT_W'(1);
            end else begin
              b_we    = 1'b1;
              b_wa    = bh_dec;
              bh_next = bh_dec;
              bf_next = bf + CNT_W'(1);
            end
          end else if (op == qmi_pkg::OP_POP) begin
            if (empty) begin
              status_acc = qmi_pkg::ST_EMPTY;
            end else begin
              pop_acc = 1'b1;
              fh_next = fh_inc;
              if (rebal) begin
                // The moved word lands where the old tail index of the front half points.
                bh_next  = bh_inc;
                bf_next  = bf - CNT_W'(1);
                move_acc = 1'b1;
              end else begin
                ff_next = ff - CNT_W'(1);
              end
            end
          end else begin
            status_acc = qmi_pkg::ST_OK;
          end
        end
      end
      qmi_pkg::S_EXEC: begin
        state_next = qmi_pkg::S_IDLE;
        if (move_pend) begin
          f_we = 1'b1;
          f_wa = mv_addr;
          f_wd = b_rd;
        end
      end
      default: state_next = qmi_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      front_mem[f_wa] <= f_wd;
    end
    if (rd_en) begin
      f_rd <= front_mem[fh];
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      back_mem[b_wa] <= v_store;
    end
    if (rd_en) begin
      b_rd <= back_mem[bh];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qmi_pkg::S_IDLE;
      fh        <= '0;
      bh        <= '0;
      ff        <= '0;
      bf        <= '0;
      res_valid <= 1'b0;
      move_pend <= 1'b0;
      pop_pend  <= 1'b0;
    end else begin
      state <= state_next;
      fh    <= fh_next;
      bh    <= bh_next;
      ff    <= ff_next;
      bf    <= bf_next;
      if (accept) begin
        move_pend <= move_acc;
        pop_pend  <= pop_acc;
      end
      if (state == qmi_pkg::S_EXEC) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mv_addr  <= fh_tail;
      status_r <= status_acc;
    end
    if (state == qmi_pkg::S_EXEC) begin
      popped_value <= pop_pend ? rd_ext[qmi_pkg::OUT_W-1:0] : '0;
      status       <= status_r;
    end
  end

  `QMI_ASSERT(a_balance, clk, rst, (ff == bf) || (ff == bf + CNT_W'(1)), "halves out of balance")
  `QMI_ASSERT(a_bound, clk, rst, total <= SUM_W'(CAPACITY), "fill exceeds capacity")
  `QMI_ASSERT(a_slot_free, clk, rst, accept |=> (state == qmi_pkg::S_EXEC) && !res_valid, "result register busy during execution")
  `QMI_ASSERT(a_result, clk, rst, (state == qmi_pkg::S_EXEC) |=> res_valid, "result not delivered")
  `QMI_ASSERT(a_zero_on_error, clk, rst, (res_valid && status != qmi_pkg::ST_OK) |-> (popped_value == '0), "nonzero value with error status")

endmodule

@@ dv/queue_with_middle_insert_tb.sv @@
// Self-checking testbench for the queue with middle insertion.
`timescale 1ns / 1ps

typedef struct packed {
  logic signed [31:0] popped;
  logic [1:0]         status;
} queue_outcome_t;

class queue_scoreboard;
  logic signed [31:0] contents[$];
  queue_outcome_t     pending_outcomes[$];
  int                 capacity;
  int                 mismatches;

  function new(int cap);
    capacity   = cap;
    mismatches = 0;
  endfunction

  function int fill_level();
    return contents.size();
  endfunction

  function int pending_count();
    return pending_outcomes.size();
  endfunction

  // Applies one word to the sequence and returns what the block should report for it.
  function queue_outcome_t predict_outcome(logic [1:0] op, logic signed [31:0] value);
    queue_outcome_t r;
    r.popped = '0;
    r.status = qmi_pkg::ST_OK;
    case (op)
      qmi_pkg::OP_PUSH, qmi_pkg::OP_MIDDLE: begin
        if (contents.size() >= capacity) begin
          r.status = qmi_pkg::ST_FULL;
        end else if (op == qmi_pkg::OP_PUSH) begin
          contents.push_back(value);
        end else begin
          // The middle slot is ceil(n/2), which is the tail for n of 0 or 1.
          contents.insert((contents.size() + 1) / 2, value);
        end
      end
      qmi_pkg::OP_POP: begin
        if (contents.size() == 0) begin
          r.status = qmi_pkg::ST_EMPTY;
        end else begin
          r.popped = contents.pop_front();
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function void note_word(logic [1:0] op, logic signed [31:0] value);
    pending_outcomes.push_back(predict_outcome(op, value));
  endfunction

  function void flag(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch: %s expected %08h got %08h", what, want, got);
    end
  endfunction

  function void check_result(logic signed [31:0] popped, logic [1:0] status);
    queue_outcome_t want;
    if (pending_outcomes.size() == 0) begin
      flag("result word with nothing pending, popped_value", '0, popped);
      return;
    end
    want = pending_outcomes.pop_front();
    if (want.popped !== popped) flag("popped_value", want.popped, popped);
    if (want.status !== status) flag("status", 32'(want.status), 32'(status));
  endfunction
endclass

module queue_with_middle_insert_tb;

  localparam int QUEUE_CAP = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               op_valid = 1'b0;
  logic               op_ready;
  logic [1:0]         op = qmi_pkg::OP_PUSH;
  logic signed [31:0] value = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic signed [31:0] popped_value;
  logic [1:0]         status;

  queue_scoreboard sb = new(QUEUE_CAP);
  int cycle_count = 0;
  int burst_left = 1;

  queue_with_middle_insert #(
    .CAPACITY(QUEUE_CAP),
    .DATA_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .op_valid(op_valid),
    .op_ready(op_ready),
    .op(op),
    .value(value),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .popped_value(popped_value),
    .status(status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check_result(popped_value, status);
  end

  // The receiver switches between always ready, random stalls and long stall windows.
  int sink_mode = 0;
  int sink_tick = 0;
  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      sink_tick++;
      if (sink_tick % 64 == 0) sink_mode = $urandom_range(0, 2);
      case (sink_mode)
        0: res_ready <= 1'b1;
        1: res_ready <= ($urandom_range(0, 3) != 0);
        default: res_ready <= ((sink_tick % 24) < 6);
      endcase
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [1:0] o, input logic [31:0] v);
    op       <= o;
    value    <= v;
    op_valid <= 1'b1;
    @(posedge clk);
    while (!op_ready) @(posedge clk);
    sb.note_word(o, v);
    @(negedge clk);
  endtask

  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 5);
      op_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Weights are percentages; whatever is left over goes to the unused op code.
  task automatic send_random(input int w_push, input int w_mid, input int w_pop);
    int r;
    logic [1:0] o;
    r = $urandom_range(0, 99);
    if (r < w_push) o = qmi_pkg::OP_PUSH;
    else if (r < w_push + w_mid) o = qmi_pkg::OP_MIDDLE;
    else if (r < w_push + w_mid + w_pop) o = qmi_pkg::OP_POP;
    else o = OP_UNUSED;
    send_word(o, pick_value());
    pace_sender();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty queue, the unused code, middle inserts at sizes zero and one, and extreme values.
    send_word(qmi_pkg::OP_POP, 32'h1234_5678);
    send_word(OP_UNUSED, 32'hFFFF_FFFF);
    send_word(qmi_pkg::OP_MIDDLE, 32'h7FFF_FFFF);
    send_word(qmi_pkg::OP_MIDDLE, 32'h8000_0000);
    send_word(qmi_pkg::OP_PUSH, 32'h0000_0000);
    send_word(qmi_pkg::OP_MIDDLE, 32'hFFFF_FFFF);
    send_word(qmi_pkg::OP_PUSH, 32'h5555_5555);
    send_word(qmi_pkg::OP_MIDDLE, 32'hAAAA_AAAA);
    send_word(OP_UNUSED, 32'h1234_5678);
    repeat (6) send_word(qmi_pkg::OP_POP, 32'h0000_0000);
    send_word(qmi_pkg::OP_POP, 32'hFFFF_FFFF);
    send_word(qmi_pkg::OP_PUSH, 32'h0000_0001);
    send_word(qmi_pkg::OP_POP, 32'h0000_0000);

    // Balanced traffic that keeps the queue near empty.
    repeat (250) send_random(30, 20, 45);
    // Fill up to capacity, then keep pushing against a full queue.
    while (sb.fill_level() < QUEUE_CAP) send_random(60, 37, 3);
    repeat (30) send_random(50, 40, 10);
    // Drain part of the way with pointers wrapped around both halves.
    repeat (300) send_random(15, 15, 70);

    op_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/qmi_pkg.sv
rtl/queue_with_middle_insert.sv
dv/queue_with_middle_insert_tb.sv
